FILE: rtl/sstw_pkg.sv
// shared types, constants and the character-to-segment table for the two-wire display sender
package sstw_pkg;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_SHOW   = 2'd1,
    KIND_BRIGHT = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    TS_IDLE  = 2'd0,
    TS_START = 2'd1,
    TS_BYTES = 2'd2,
    TS_STOP  = 2'd3
  } tstep_e;

  typedef enum logic [1:0] {
    JOB_NONE   = 2'd0,
    JOB_SHOW   = 2'd1,
    JOB_BRIGHT = 2'd2
  } job_e;

  localparam logic [7:0] CMD_DATA    = 8'h40;
  localparam logic [7:0] CMD_ADDR    = 8'hC0;
  localparam logic [7:0] CMD_BRIGHT  = 8'h88;
  localparam logic [7:0] LEVEL_MAX   = 8'h07;
  localparam logic [7:0] TICKS_RESET = 8'd2;

  // queue entry layout, segment bytes on top
  localparam int unsigned E_KIND_LSB = 0;
  localparam int unsigned E_SENSE    = 2;
  localparam int unsigned E_CMD_LSB  = 3;
  localparam int unsigned E_SEG_LSB  = 11;

  // one result item, clk_out in the lowest bit
  typedef struct packed {
    logic sequence_done;
    logic nack;
    logic ack_strobe;
    logic accepted;
    logic busy_res;
    logic dio_listen;
    logic dio_out;
    logic clk_out;
  } res_t;

  localparam logic [9:0][7:0] DIGIT_SEGS = {
    8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };

  function automatic logic [7:0] glyph(input logic [7:0] ch);
    logic [7:0] seg;
    logic [7:0] idx;
    idx = ch - 8'h30;
    seg = 8'h00;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      seg = DIGIT_SEGS[idx[3:0]];
    end else begin
      case (ch)
        8'h2D:        seg = 8'h40;  // dash
        8'h41, 8'h61: seg = 8'h77;
        8'h62:        seg = 8'h7C;
        8'h43, 8'h63: seg = 8'h58;
        8'h45, 8'h65: seg = 8'h79;
        8'h46, 8'h66: seg = 8'h71;
        8'h48, 8'h68: seg = 8'h76;
        8'h4C:        seg = 8'h38;
        8'h50, 8'h70: seg = 8'h73;
        8'h72:        seg = 8'h50;
        8'h55, 8'h75: seg = 8'h3E;
        8'h5F:        seg = 8'h08;  // underscore
        default:      seg = 8'h00;
      endcase
    end
    return seg;
  endfunction

endpackage

FILE: rtl/seven_segment_two_wire_sender.sv
// top level of the two-wire seven-segment display sender
// Takes one item per clock while the queue has room: tick items step the pin sequencer, show
// and brightness requests load a job when idle. Each item gives one result, through a two-entry
// queue and a result register; the sequencer handles one item per cycle, so input and output run
// at one transaction per clock when the output is not stalled. Bus speed on the pins is set by
// the ticks-per-phase register: each pin phase lasts that many tick items (zero acts as one).
module seven_segment_two_wire_sender import sstw_pkg::*; #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // char_zero, char_one, char_two, char_three, char_count, level, dio_sense, zero pad
  input  logic [47:0] s_axis_tdata,
  // kind
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // clk_out, dio_out, dio_listen, busy_res, accepted, ack_strobe, nack, sequence_done
  output logic [7:0]  m_axis_tdata
);

  localparam int unsigned ENTRY_W = E_SEG_LSB + 8 * DIGIT_COUNT;

  logic [ENTRY_W-1:0] front_entry;
  logic [ENTRY_W-1:0] q_data;
  logic               q_full;
  logic               q_valid;
  logic               q_pop;
  logic               push;
  res_t               res;

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  sstw_front #(
    .DIGIT_COUNT(DIGIT_COUNT),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .kind_i      (s_axis_tuser),
    .char_zero_i (s_axis_tdata[7:0]),
    .char_one_i  (s_axis_tdata[15:8]),
    .char_two_i  (s_axis_tdata[23:16]),
    .char_three_i(s_axis_tdata[31:24]),
    .char_count_i(s_axis_tdata[34:32]),
    .level_i     (s_axis_tdata[42:35]),
    .dio_sense_i (s_axis_tdata[43]),
    .entry_o     (front_entry)
  );

  sstw_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(front_entry),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_data_o (q_data)
  );

  sstw_back #(
    .DIGIT_COUNT(DIGIT_COUNT),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .q_valid_i  (q_valid),
    .q_data_i   (q_data),
    .q_pop_o    (q_pop),
    .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tdata = res;

endmodule

FILE: rtl/sstw_front.sv
// front end: classifies input items and maps characters and levels to bus bytes
module sstw_front import sstw_pkg::*; #(
  parameter int unsigned DIGIT_COUNT = 4,
  parameter int unsigned ENTRY_W     = E_SEG_LSB + 8 * DIGIT_COUNT
) (
  input  logic [1:0]         kind_i,
  input  logic [7:0]         char_zero_i,
  input  logic [7:0]         char_one_i,
  input  logic [7:0]         char_two_i,
  input  logic [7:0]         char_three_i,
  input  logic [2:0]         char_count_i,
  input  logic [7:0]         level_i,
  input  logic               dio_sense_i,
  output logic [ENTRY_W-1:0] entry_o
);

  kind_e                       kind;
  logic [7:0]                  cmd;
  logic [3:0][7:0]             chars;
  logic [DIGIT_COUNT-1:0][7:0] segs;

  assign kind  = kind_e'(kind_i);
  assign chars = {char_three_i, char_two_i, char_one_i, char_zero_i};

  always_comb begin
    case (kind)
      KIND_SHOW:   cmd = CMD_DATA;
      KIND_BRIGHT: cmd = CMD_BRIGHT | ((level_i > LEVEL_MAX) ? LEVEL_MAX : level_i);
      default:     cmd = 8'h00;
    endcase
  end

  // digits past the count, and past the fourth, stay blank
  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (i < 4 && 32'(char_count_i) > i) begin
        segs[i] = glyph(chars[i]);
      end else begin
        segs[i] = 8'h00;
      end
    end
  end

  assign entry_o = {segs, cmd, dio_sense_i, kind_i};

endmodule

FILE: rtl/sstw_queue.sv
// two-entry queue between the front end and the pin sequencer
module sstw_queue #(
  parameter int unsigned WIDTH = 43
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [1:0][WIDTH-1:0] mem_q;
  logic                  wr_ptr_q, wr_ptr_d;
  logic                  rd_ptr_q, rd_ptr_d;
  logic [1:0]            count_q, count_d;

  assign full_o     = count_q == 2'd2;
  assign valid_o    = count_q != 2'd0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/sstw_back.sv
// back end: pin phase sequencer for start, bytes with acknowledge and stop, plus result register
module sstw_back import sstw_pkg::*; #(
  parameter int unsigned DIGIT_COUNT = 4,
  parameter int unsigned ENTRY_W     = E_SEG_LSB + 8 * DIGIT_COUNT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               q_valid_i,
  input  logic [ENTRY_W-1:0] q_data_i,
  output logic               q_pop_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output res_t               res_o
);

  localparam int unsigned SW = $clog2(DIGIT_COUNT + 2);

  logic [7:0]                  tpp_q;
  logic [7:0]                  timer_q, timer_d;
  logic [2:0]                  phase_q, phase_d;
  logic [3:0]                  bits_q, bits_d;
  logic [7:0]                  shift_q, shift_d;
  logic [SW-1:0]               slot_q, slot_d;
  tstep_e                      tstep_q, tstep_d;
  job_e                        job_q, job_d;
  logic [DIGIT_COUNT-1:0][7:0] seg_q, seg_d;
  logic [7:0]                  cmd_q, cmd_d;
  logic                        clk_q, clk_d;
  logic                        dio_q, dio_d;
  logic                        out_valid_q, out_valid_d;
  res_t                        out_q, out_d;

  kind_e                       e_kind;
  logic                        e_sense;
  logic [7:0]                  e_cmd;
  logic [DIGIT_COUNT-1:0][7:0] e_seg;
  logic                        pop;
  logic                        busy;
  logic                        fin;
  logic                        strobe, nack, done, accepted;
  logic [7:0]                  next_seg;

  assign e_kind  = kind_e'(q_data_i[E_KIND_LSB +: 2]);
  assign e_sense = q_data_i[E_SENSE];
  assign e_cmd   = q_data_i[E_CMD_LSB +: 8];
  assign e_seg   = q_data_i[E_SEG_LSB +: 8 * DIGIT_COUNT];

  assign pop     = q_valid_i && (!out_valid_q || res_ready_i);
  assign q_pop_o = pop;
  assign busy    = tstep_q != TS_IDLE;

  // segment byte for the slot after the current one
  always_comb begin
    next_seg = 8'h00;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (slot_q == SW'(i + 1)) begin
        next_seg = seg_q[i];
      end
    end
  end

  always_comb begin
    timer_d  = timer_q;
    phase_d  = phase_q;
    bits_d   = bits_q;
    shift_d  = shift_q;
    slot_d   = slot_q;
    tstep_d  = tstep_q;
    job_d    = job_q;
    seg_d    = seg_q;
    cmd_d    = cmd_q;
    clk_d    = clk_q;
    dio_d    = dio_q;
    strobe   = 1'b0;
    nack     = 1'b0;
    done     = 1'b0;
    accepted = 1'b0;
    fin      = 1'b0;

    if (pop) begin
      case (e_kind)
        KIND_TICK: begin
          if (busy && timer_q != 8'd0) begin
            timer_d = timer_q - 8'd1;
          end else if (busy) begin
            // end of stop: either chain the address transaction or finish
            if (tstep_q == TS_STOP && phase_q >= 3'd4) begin
              if (job_q == JOB_SHOW && slot_q == '0) begin
                slot_d  = SW'(1);
                shift_d = CMD_ADDR;
                tstep_d = TS_START;
                phase_d = 3'd0;
              end else begin
                tstep_d = TS_IDLE;
                job_d   = JOB_NONE;
                phase_d = 3'd0;
                bits_d  = 4'd0;
                done    = 1'b1;
                fin     = 1'b1;
              end
            end
            if (!fin) begin
              case (tstep_d)
                TS_START: begin
                  if (phase_d == 3'd0) begin
                    clk_d   = 1'b1;
                    dio_d   = 1'b1;
                    phase_d = 3'd1;
                  end else if (phase_d == 3'd1) begin
                    dio_d   = 1'b0;
                    phase_d = 3'd2;
                  end else begin
                    clk_d   = 1'b0;
                    tstep_d = TS_BYTES;
                    bits_d  = 4'd0;
                    phase_d = 3'd0;
                  end
                end
                TS_BYTES: begin
                  if (bits_q < 4'd8) begin
                    if (phase_q == 3'd0) begin
                      clk_d   = 1'b0;
                      phase_d = 3'd1;
                    end else if (phase_q == 3'd1) begin
                      dio_d   = shift_q[0];
                      phase_d = 3'd2;
                    end else begin
                      clk_d   = 1'b1;
                      shift_d = {1'b0, shift_q[7:1]};
                      bits_d  = bits_q + 4'd1;
                      phase_d = 3'd0;
                    end
                  end else begin
                    // acknowledge slot with dio released
                    if (phase_q == 3'd0) begin
                      clk_d   = 1'b0;
                      dio_d   = 1'b1;
                      phase_d = 3'd1;
                    end else if (phase_q == 3'd1) begin
                      clk_d   = 1'b1;
                      phase_d = 3'd2;
                    end else begin
                      strobe  = 1'b1;
                      nack    = e_sense;
                      clk_d   = 1'b0;
                      phase_d = 3'd0;
                      bits_d  = 4'd0;
                      if (job_q == JOB_SHOW && slot_q >= SW'(1) &&
                          slot_q <= SW'(DIGIT_COUNT)) begin
                        slot_d  = slot_q + SW'(1);
                        shift_d = next_seg;
                      end else begin
                        tstep_d = TS_STOP;
                      end
                    end
                  end
                end
                TS_STOP: begin
                  case (phase_d)
                    3'd0:    clk_d = 1'b0;
                    3'd1:    dio_d = 1'b0;
                    3'd2:    clk_d = 1'b1;
                    default: dio_d = 1'b1;
                  endcase
                  phase_d = phase_d + 3'd1;
                end
                default: begin
                end
              endcase
            end
            if (tstep_d != TS_IDLE) begin
              timer_d = (tpp_q == 8'd0) ? 8'd0 : tpp_q - 8'd1;
            end else begin
              timer_d = 8'd0;
            end
          end
        end
        KIND_SHOW, KIND_BRIGHT: begin
          if (!busy) begin
            accepted = 1'b1;
            cmd_d    = e_cmd;
            if (e_kind == KIND_SHOW) begin
              seg_d = e_seg;
              job_d = JOB_SHOW;
            end else begin
              job_d = JOB_BRIGHT;
            end
            slot_d  = '0;
            shift_d = e_cmd;
            bits_d  = 4'd0;
            phase_d = 3'd0;
            timer_d = 8'd0;
            tstep_d = TS_START;
          end
        end
        default: begin
        end
      endcase
    end

    out_d.clk_out       = clk_d;
    out_d.dio_out       = dio_d;
    out_d.dio_listen    = tstep_d == TS_BYTES && bits_d == 4'd8 && phase_d >= 3'd1;
    out_d.busy_res      = tstep_d != TS_IDLE;
    out_d.accepted      = accepted;
    out_d.ack_strobe    = strobe;
    out_d.nack          = nack;
    out_d.sequence_done = done;

    if (pop) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpp_q       <= TICKS_RESET;
      timer_q     <= 8'd0;
      phase_q     <= 3'd0;
      bits_q      <= 4'd0;
      shift_q     <= 8'd0;
      slot_q      <= '0;
      tstep_q     <= TS_IDLE;
      job_q       <= JOB_NONE;
      seg_q       <= '0;
      cmd_q       <= 8'd0;
      clk_q       <= 1'b1;
      dio_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tpp_q <= cfg_wdata_i;
      end
      timer_q     <= timer_d;
      phase_q     <= phase_d;
      bits_q      <= bits_d;
      shift_q     <= shift_d;
      slot_q      <= slot_d;
      tstep_q     <= tstep_d;
      job_q       <= job_d;
      seg_q       <= seg_d;
      cmd_q       <= cmd_d;
      clk_q       <= clk_d;
      dio_q       <= dio_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= out_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule
